// ----- rtl/wii_pkg.sv -----
// Package for the isotropic well index pipeline: constants, codes and sideband types.
// Used by every module in rtl/; has no dependencies of its own.
`default_nettype none

package wii_pkg;

    // fixed-point coefficients
    localparam logic [29:0] RE_COEF  = 30'd601295421;   // 0.14 in Q.32
    localparam logic [29:0] LN2_COEF = 30'd744261118;   // ln2 in Q.30
    localparam logic [31:0] TWO_PI   = 32'd3373259426;  // 2*pi in Q.29
    localparam int          LOG_FRAC = 28;

    localparam logic [47:0] INDEX_MAX = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_ORIENT = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;
    localparam logic [1:0] CFG_SKIN   = 2'd2;

    // orientation codes
    localparam logic [1:0] OR_GENERIC  = 2'd0;
    localparam logic [1:0] OR_VERTICAL = 2'd1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RAD_ZERO = 2'd1;
    localparam logic [1:0] ST_DEN_BAD  = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // sideband carried through the sub-pipelines
    typedef struct packed {
        logic [95:0] num;
    } t_sq_sb;

    typedef struct packed {
        logic [31:0] re;
        logic [95:0] num;
    } t_log_sb;

    typedef struct packed {
        logic [31:0] re;
        logic [1:0]  status;
    } t_div_sb;

    localparam int SQ_SB_W  = $bits(t_sq_sb);
    localparam int LOG_SB_W = $bits(t_log_sb);
    localparam int DIV_SB_W = $bits(t_div_sb);

endpackage

`default_nettype wire

// ----- rtl/wii_sqrt.sv -----
// Pipelined integer square root of a 66-bit radicand, one result bit per stage.
// Depends on wii_pkg for the default sideband width.
`default_nettype none

module wii_sqrt #(
    parameter int SB_W = wii_pkg::SQ_SB_W
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [65:0]     i_radicand,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_valid,
    output logic [32:0]          o_root,
    output logic [SB_W-1:0]      o_sb
);

    logic            r_v    [0:33];
    logic [65:0]     r_rad  [0:33];
    logic [34:0]     r_rem  [0:33];
    logic [32:0]     r_root [0:33];
    logic [SB_W-1:0] r_sb   [0:33];

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= i_radicand;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_sb[0]   <= i_sb;
    end

    // one root bit per stage, restoring
    for (genvar k = 0; k < 33; k++) begin : g_stage
        logic [36:0] w_sh;
        logic [36:0] w_trial;
        logic        w_take;

        assign w_sh    = {r_rem[k], r_rad[k][65:64]};
        assign w_trial = {2'b00, r_root[k], 2'b01};
        assign w_take  = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k+1] <= {r_rad[k][63:0], 2'b00};
            r_sb[k+1]  <= r_sb[k];
            if (w_take) begin
                r_rem[k+1]  <= 35'(w_sh - w_trial);
                r_root[k+1] <= {r_root[k][31:0], 1'b1};
            end else begin
                r_rem[k+1]  <= w_sh[34:0];
                r_root[k+1] <= {r_root[k][31:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[33];
    assign o_root  = r_root[33];
    assign o_sb    = r_sb[33];

endmodule

`default_nettype wire

// ----- rtl/wii_log2.sv -----
// Pipelined log2 in Q.28: leading-one stage, then one squaring per fraction bit.
// Depends on wii_pkg for LOG_FRAC and the default sideband width.
`default_nettype none

module wii_log2 #(
    parameter int SB_W = wii_pkg::LOG_SB_W
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [31:0]     i_x,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_valid,
    output logic [32:0]          o_log,
    output logic [SB_W-1:0]      o_sb
);

    localparam int NF = wii_pkg::LOG_FRAC;

    logic            r_v   [0:NF];
    logic [31:0]     r_m   [0:NF];
    logic [32:0]     r_res [0:NF];
    logic [SB_W-1:0] r_sb  [0:NF];

    logic [4:0]  w_msb;
    logic [31:0] w_norm;

    // leading one and normalize
    always_comb begin
        w_msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_x[i]) begin
                w_msb = 5'(i);
            end
        end
        w_norm = i_x << (5'd31 - w_msb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0]   <= w_norm;
        r_res[0] <= {w_msb, {NF{1'b0}}};
        r_sb[0]  <= i_sb;
    end

    // square, one fraction bit per stage
    for (genvar k = 0; k < NF; k++) begin : g_stage
        logic [63:0] w_sq;
        logic [32:0] w_t;

        assign w_sq = 64'(r_m[k]) * 64'(r_m[k]);
        assign w_t  = w_sq[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sb[k+1] <= r_sb[k];
            if (w_t[32]) begin
                r_m[k+1]   <= w_t[32:1];
                r_res[k+1] <= r_res[k] | (33'd1 << (NF - 1 - k));
            end else begin
                r_m[k+1]   <= w_t[31:0];
                r_res[k+1] <= r_res[k];
            end
        end
    end

    assign o_valid = r_v[NF];
    assign o_log   = r_res[NF];
    assign o_sb    = r_sb[NF];

endmodule

`default_nettype wire

// ----- rtl/wii_div.sv -----
// Pipelined 96 / 39-bit divider with 48-bit quotient and overflow flag.
// Depends on wii_pkg for the default sideband width.
`default_nettype none

module wii_div #(
    parameter int SB_W = wii_pkg::DIV_SB_W
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [95:0]     i_num,
    input  wire logic [38:0]     i_div,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_valid,
    output logic [47:0]          o_quot,
    output logic                 o_sat,
    output logic [SB_W-1:0]      o_sb
);

    logic            r_v   [0:48];
    logic [38:0]     r_rem [0:48];
    logic [47:0]     r_low [0:48];
    logic [47:0]     r_q   [0:48];
    logic [38:0]     r_div [0:48];
    logic            r_sat [0:48];
    logic [SB_W-1:0] r_sb  [0:48];

    logic w_sat;

    // quotient too big for 48 bits when the upper half already reaches the divisor
    assign w_sat = (i_num[95:48] >= 48'(i_div));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_sat ? '0 : i_num[86:48];
        r_low[0] <= i_num[47:0];
        r_q[0]   <= '0;
        r_div[0] <= i_div;
        r_sat[0] <= w_sat;
        r_sb[0]  <= i_sb;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < 48; k++) begin : g_stage
        logic [39:0] w_sh;
        logic        w_take;

        assign w_sh   = {r_rem[k], r_low[k][47]};
        assign w_take = (w_sh >= {1'b0, r_div[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_low[k+1] <= {r_low[k][46:0], 1'b0};
            r_div[k+1] <= r_div[k];
            r_sat[k+1] <= r_sat[k];
            r_sb[k+1]  <= r_sb[k];
            r_q[k+1]   <= {r_q[k][46:0], w_take};
            if (w_take) begin
                r_rem[k+1] <= 39'(w_sh - {1'b0, r_div[k]});
            end else begin
                r_rem[k+1] <= w_sh[38:0];
            end
        end
    end

    assign o_valid = r_v[48];
    assign o_quot  = r_q[48];
    assign o_sat   = r_sat[48];
    assign o_sb    = r_sb[48];

endmodule

`default_nettype wire

// ----- rtl/well_index_isotropic.sv -----
// Top level of the isotropic well index pipeline.
// Depends on wii_pkg, wii_sqrt, wii_log2 and wii_div.
//
// channel   direction  handshake                 payload
// command   in         start & !busy             i_size_x, i_size_y, i_size_z, i_permeability
// result    out        o_valid (one cycle)       o_equiv_radius, o_well_index, o_status
// config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// One cell enters every cycle; busy stays low.
// The pipe has 4 front stages, 34 root stages, 1 scaling, 29 log2 stages,
// 3 denominator stages, 49 divider stages and the output register.
// Reset clears the valid bits and loads the register defaults.
// Results cannot be held off, so nothing in the pipe ever stalls.
`default_nettype none

module well_index_isotropic (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_size_x,
    input  wire logic [31:0] i_size_y,
    input  wire logic [31:0] i_size_z,
    input  wire logic [31:0] i_permeability,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    output logic [31:0]      o_equiv_radius,
    output logic [47:0]      o_well_index,
    output logic [1:0]       o_status
);

    // configuration registers
    logic [1:0]  r_orient;
    logic [31:0] r_well_radius;
    logic [23:0] r_skin;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient      <= wii_pkg::OR_VERTICAL;
            r_well_radius <= 32'd6554;
            r_skin        <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wii_pkg::CFG_ORIENT: r_orient      <= i_cfg_data[1:0];
                wii_pkg::CFG_RADIUS: r_well_radius <= i_cfg_data;
                wii_pkg::CFG_SKIN:   r_skin        <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // stage A: pick sizes by orientation
    logic        r_a_v;
    logic [31:0] r_a_a, r_a_b, r_a_h, r_a_k;
    logic [31:0] w_a, w_b, w_h;

    always_comb begin
        case (r_orient)
            wii_pkg::OR_GENERIC: begin
                w_a = i_size_y; w_b = i_size_z; w_h = i_size_x;
            end
            wii_pkg::OR_VERTICAL: begin
                w_a = i_size_x; w_b = i_size_y; w_h = i_size_z;
            end
            default: begin
                w_a = i_size_x; w_b = i_size_z; w_h = i_size_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_a <= w_a;
        r_a_b <= w_b;
        r_a_h <= w_h;
        r_a_k <= i_permeability;
    end

    // stage B: squares and K*h
    logic        r_b_v;
    logic [63:0] r_b_aa, r_b_bb, r_b_kh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_aa <= 64'(r_a_a) * 64'(r_a_a);
        r_b_bb <= 64'(r_a_b) * 64'(r_a_b);
        r_b_kh <= 64'(r_a_k) * 64'(r_a_h);
    end

    // stage C: sum of squares, partial products of K*h*2pi
    logic        r_c_v;
    logic [64:0] r_c_sum;
    logic [63:0] r_c_plo, r_c_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sum <= 65'(r_b_aa) + 65'(r_b_bb);
        r_c_plo <= 64'(r_b_kh[31:0]) * 64'(wii_pkg::TWO_PI);
        r_c_phi <= 64'(r_b_kh[63:32]) * 64'(wii_pkg::TWO_PI);
    end

    // stage D: numerator
    logic        r_d_v;
    logic [64:0] r_d_sum;
    logic [95:0] r_d_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_sum <= r_c_sum;
        r_d_num <= 96'(r_c_plo) + {r_c_phi, 32'd0};
    end

    // square root
    wii_pkg::t_sq_sb w_sq_in, w_sq_out;
    logic            w_sq_v;
    logic [32:0]     w_root;

    assign w_sq_in.num = r_d_num;

    wii_sqrt #(
        .SB_W (wii_pkg::SQ_SB_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_d_v),
        .i_radicand ({1'b0, r_d_sum}),
        .i_sb       (w_sq_in),
        .o_valid    (w_sq_v),
        .o_root     (w_root),
        .o_sb       (w_sq_out)
    );

    // stage E: re = root * 0.14, rounded
    logic        r_e_v;
    logic [31:0] r_e_re;
    logic [95:0] r_e_num;
    logic [62:0] w_re_prod;

    assign w_re_prod = 63'(w_root) * 63'(wii_pkg::RE_COEF) + (63'd1 << 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_re  <= {1'b0, w_re_prod[62:32]};
        r_e_num <= w_sq_out.num;
    end

    // log2 of re and of the well radius, side by side
    wii_pkg::t_log_sb w_lr_in, w_lr_out;
    logic             w_lr_v, w_lw_v;
    logic [32:0]      w_lr, w_lw;
    logic             w_rw_zero;

    assign w_lr_in.re  = r_e_re;
    assign w_lr_in.num = r_e_num;

    wii_log2 #(
        .SB_W (wii_pkg::LOG_SB_W)
    ) u_log_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_v),
        .i_x     (r_e_re),
        .i_sb    (w_lr_in),
        .o_valid (w_lr_v),
        .o_log   (w_lr),
        .o_sb    (w_lr_out)
    );

    wii_log2 #(
        .SB_W (1)
    ) u_log_rw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_v),
        .i_x     (r_well_radius),
        .i_sb    (r_well_radius == '0),
        .o_valid (w_lw_v),
        .o_log   (w_lw),
        .o_sb    (w_rw_zero)
    );

    // stage F1: log difference, magnitude and sign
    logic        r_f1_v, r_f1_neg, r_f1_rw0;
    logic [32:0] r_f1_mag;
    logic [31:0] r_f1_re;
    logic [95:0] r_f1_num;
    logic [33:0] w_d2;

    assign w_d2 = {1'b0, w_lr} - {1'b0, w_lw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= w_lr_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_neg <= w_d2[33];
        r_f1_mag <= w_d2[33] ? 33'(-w_d2) : w_d2[32:0];
        r_f1_rw0 <= w_rw_zero;
        r_f1_re  <= w_lr_out.re;
        r_f1_num <= w_lr_out.num;
    end

    // stage F2: times ln2, rounded
    logic        r_f2_v, r_f2_neg, r_f2_rw0;
    logic [32:0] r_f2_lnv;
    logic [31:0] r_f2_re;
    logic [95:0] r_f2_num;
    logic [62:0] w_ln_prod;

    assign w_ln_prod = 63'(r_f1_mag) * 63'(wii_pkg::LN2_COEF) + (63'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2_neg <= r_f1_neg;
        r_f2_lnv <= w_ln_prod[62:30];
        r_f2_rw0 <= r_f1_rw0;
        r_f2_re  <= r_f1_re;
        r_f2_num <= r_f1_num;
    end

    // stage F3: denominator and early status
    logic        r_f3_v;
    logic [38:0] r_f3_dd;
    logic [95:0] r_f3_num;
    wii_pkg::t_div_sb r_f3_sb;
    logic signed [37:0] w_lnv_s, w_skin_s, w_den;
    logic [1:0]  w_st;

    always_comb begin
        w_lnv_s  = r_f2_neg ? -$signed({5'd0, r_f2_lnv}) : $signed({5'd0, r_f2_lnv});
        w_skin_s = $signed({{2{r_skin[23]}}, r_skin, 12'd0});
        w_den    = w_lnv_s + w_skin_s;
        if (r_f2_rw0) begin
            w_st = wii_pkg::ST_RAD_ZERO;
        end else if (r_f2_re == '0 || w_den <= 0) begin
            w_st = wii_pkg::ST_DEN_BAD;
        end else begin
            w_st = wii_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_v <= 1'b0;
        end else begin
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f3_dd        <= {w_den, 1'b0};
        r_f3_num       <= r_f2_num;
        r_f3_sb.re     <= r_f2_re;
        r_f3_sb.status <= w_st;
    end

    // divider
    wii_pkg::t_div_sb w_dv_out;
    logic             w_dv_v, w_dv_sat;
    logic [47:0]      w_quot;

    wii_div #(
        .SB_W (wii_pkg::DIV_SB_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f3_v),
        .i_num   (r_f3_num),
        .i_div   (r_f3_dd),
        .i_sb    (r_f3_sb),
        .o_valid (w_dv_v),
        .o_quot  (w_quot),
        .o_sat   (w_dv_sat),
        .o_sb    (w_dv_out)
    );

    // output register: final status and index
    logic        r_o_v;
    logic [31:0] r_o_re;
    logic [47:0] r_o_idx;
    logic [1:0]  r_o_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_re <= w_dv_out.re;
        if (w_dv_out.status != wii_pkg::ST_OK) begin
            r_o_idx <= '0;
            r_o_st  <= w_dv_out.status;
        end else if (w_dv_sat) begin
            r_o_idx <= wii_pkg::INDEX_MAX;
            r_o_st  <= wii_pkg::ST_SAT;
        end else begin
            r_o_idx <= w_quot;
            r_o_st  <= wii_pkg::ST_OK;
        end
    end

    assign o_valid        = r_o_v;
    assign o_equiv_radius = r_o_re;
    assign o_well_index   = r_o_idx;
    assign o_status       = r_o_st;

    // checks
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lr_v == w_lw_v)
        else $error("log lanes out of step");

    a_flag_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == wii_pkg::ST_RAD_ZERO || o_status == wii_pkg::ST_DEN_BAD)
        |-> o_well_index == '0)
        else $error("flagged item carries nonzero index");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == wii_pkg::ST_SAT |-> o_well_index == wii_pkg::INDEX_MAX)
        else $error("saturated item not at full scale");

    a_zero_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_equiv_radius == '0 && r_well_radius != '0
        |-> o_status == wii_pkg::ST_DEN_BAD)
        else $error("zero radius item not flagged");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for well_index_isotropic: directed and random well cells, checked result by result.
// Depends on wii_pkg and the RTL in rtl/; the expected results come from a predictor in this file.
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] OR_HORIZONTAL = 2'd2;
    localparam logic [1:0] OR_SPARE      = 2'd3;
    localparam int         PIPE_DRAIN    = 130;
    localparam int         STALL_LIMIT   = 5000;

    typedef struct packed {
        logic [31:0] re;
        logic [47:0] idx;
        logic [1:0]  st;
    } t_cell_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_size_x = '0;
    logic [31:0] i_size_y = '0;
    logic [31:0] i_size_z = '0;
    logic [31:0] i_permeability = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic [31:0] o_equiv_radius;
    logic [47:0] o_well_index;
    logic [1:0]  o_status;

    // shadow of the configuration registers
    logic [1:0]  orient_q;
    logic [31:0] rw_q;
    logic [23:0] skin_q;

    t_cell_res   cell_expect_q[$];
    int          err_count = 0;
    int          quiet_cnt = 0;
    bit          no_gaps = 1'b0;

    well_index_isotropic dut (.*);

    always #5 i_clk = ~i_clk;

    // floor square root of a 66-bit sum
    function automatic logic [32:0] root66(input logic [65:0] s);
        logic [32:0] r;
        logic [32:0] c;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (33'd1 << b);
            if ({33'd0, c} * {33'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    // log2 in Q.28, fraction by repeated squaring
    function automatic longint log2_fix(input logic [31:0] x);
        int          msb;
        logic [63:0] m;
        longint      res;
        msb = 31;
        while (msb > 0 && !x[msb])
            msb--;
        m = 64'(x) << (31 - msb);
        res = longint'(msb) <<< wii_pkg::LOG_FRAC;
        for (int i = wii_pkg::LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                res += longint'(1) <<< i;
            end
        end
        return res;
    endfunction

    function automatic t_cell_res cell_predict(input logic [31:0] sx, input logic [31:0] sy,
                                               input logic [31:0] sz, input logic [31:0] k);
        t_cell_res    r;
        logic [31:0]  a, b, h;
        logic [65:0]  sum;
        logic [95:0]  scaled;
        longint       d2, lnv, den;
        logic [63:0]  mag;
        logic [127:0] num, q;
        case (orient_q)
            wii_pkg::OR_GENERIC:  begin a = sy; b = sz; h = sx; end
            wii_pkg::OR_VERTICAL: begin a = sx; b = sy; h = sz; end
            default:              begin a = sx; b = sz; h = sx; end
        endcase
        sum = 66'(a) * 66'(a) + 66'(b) * 66'(b);
        scaled = 96'(root66(sum)) * 96'(wii_pkg::RE_COEF) + (96'd1 << 31);
        r.re = scaled[63:32];
        r.idx = '0;
        r.st = wii_pkg::ST_OK;
        if (rw_q == 0) begin
            r.st = wii_pkg::ST_RAD_ZERO;
        end else if (r.re == 0) begin
            r.st = wii_pkg::ST_DEN_BAD;
        end else begin
            d2 = log2_fix(r.re) - log2_fix(rw_q);
            mag = (d2 < 0) ? 64'(-d2) : 64'(d2);
            lnv = longint'((mag * 64'(wii_pkg::LN2_COEF) + (64'd1 << 29)) >> 30);
            if (d2 < 0)
                lnv = -lnv;
            den = lnv + longint'(signed'(skin_q)) * 4096;
            if (den <= 0) begin
                r.st = wii_pkg::ST_DEN_BAD;
            end else begin
                num = 128'(64'(k) * 64'(h)) * 128'(wii_pkg::TWO_PI);
                q = num / (128'(den) * 2);
                if (q > 128'(wii_pkg::INDEX_MAX)) begin
                    r.idx = wii_pkg::INDEX_MAX;
                    r.st = wii_pkg::ST_SAT;
                end else begin
                    r.idx = q[47:0];
                end
            end
        end
        return r;
    endfunction

    // one command item; start stays high into the next item unless a gap is taken
    task automatic send_cell(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz, input logic [31:0] k);
        int gap;
        if (!no_gaps && $urandom_range(0, 99) < 8) begin
            gap = $urandom_range(1, 2);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_size_x <= sx;
        i_size_y <= sy;
        i_size_z <= sz;
        i_permeability <= k;
        do @(posedge i_clk); while (busy);
        cell_expect_q.push_back(cell_predict(sx, sy, sz, k));
    endtask

    // wait for the pipe to empty, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        start <= 1'b0;
        wait (cell_expect_q.size() == 0);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            wii_pkg::CFG_ORIENT: orient_q = data[1:0];
            wii_pkg::CFG_RADIUS: rw_q = data;
            wii_pkg::CFG_SKIN:   skin_q = data[23:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_scaled();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_cell_res e;
        if (i_rst_n && o_valid) begin
            if (cell_expect_q.size() == 0) begin
                $display("%0t: unexpected result re=%h idx=%h st=%0d", $time,
                         o_equiv_radius, o_well_index, o_status);
                err_count++;
            end else begin
                e = cell_expect_q.pop_front();
                if (o_equiv_radius !== e.re) begin
                    $display("%0t: equiv_radius exp %h got %h", $time, e.re, o_equiv_radius);
                    err_count++;
                end
                if (o_well_index !== e.idx) begin
                    $display("%0t: well_index exp %h got %h", $time, e.idx, o_well_index);
                    err_count++;
                end
                if (o_status !== e.st) begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, o_status);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_orientations();
        logic [1:0] modes[4] = '{wii_pkg::OR_GENERIC, wii_pkg::OR_VERTICAL,
                                 OR_HORIZONTAL, OR_SPARE};
        foreach (modes[m]) begin
            write_reg(wii_pkg::CFG_ORIENT, 32'(modes[m]));
            send_cell(32'h0002_0000, 32'h0003_0000, 32'h0005_0000, 32'd100);
            send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_cell(32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 32'd1);
        end
    endtask

    task automatic test_special_cases();
        write_reg(wii_pkg::CFG_ORIENT, 32'(wii_pkg::OR_VERTICAL));
        // zero equivalent radius
        send_cell(32'd0, 32'd0, 32'h0001_0000, 32'd7);
        // denominator not positive: wellbore larger than the cell
        write_reg(wii_pkg::CFG_RADIUS, 32'hFFFF_FFFF);
        send_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd5);
        // re below rw, tiny positive skin: denominator still not positive
        write_reg(wii_pkg::CFG_RADIUS, 32'd12977);
        write_reg(wii_pkg::CFG_SKIN, 32'd1);
        send_cell(32'h0001_0000, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cell(32'h0001_0000, 32'd0, 32'h0000_0001, 32'd0);
        // most negative skin
        write_reg(wii_pkg::CFG_SKIN, 32'hFF80_0000);
        send_cell(32'h0010_0000, 32'h0010_0000, 32'h0001_0000, 32'd1000);
        // zero wellbore radius takes priority
        write_reg(wii_pkg::CFG_RADIUS, 32'd0);
        send_cell(32'd0, 32'd0, 32'h0001_0000, 32'd7);
        send_cell(32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 32'd7);
        write_reg(wii_pkg::CFG_SKIN, 32'h007F_FFFF);
        write_reg(wii_pkg::CFG_RADIUS, 32'd1);
        send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_cells();
        logic [31:0] rw;
        int          skin;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(wii_pkg::CFG_ORIENT, 32'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: rw = 32'd1;
                1: rw = 32'hFFFF_FFFF;
                default: rw = rand_scaled() | 32'd1;
            endcase
            write_reg(wii_pkg::CFG_RADIUS, rw);
            case ($urandom_range(0, 3))
                0: skin = -8388608;
                1: skin = 8388607;
                default: skin = $urandom_range(0, 2 * 2097152) - 2097152;
            endcase
            write_reg(wii_pkg::CFG_SKIN, 32'(skin));
            no_gaps = (ph == 3);
            repeat (178)
                send_cell(rand_scaled(), rand_scaled(), rand_scaled(), rand_scaled());
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        orient_q = wii_pkg::OR_VERTICAL;
        rw_q = 32'd6554;
        skin_q = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_orientations();
        test_special_cases();
        test_random_cells();
        start <= 1'b0;
        wait (cell_expect_q.size() == 0);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- well_index_isotropic.f -----
rtl/wii_pkg.sv
rtl/wii_sqrt.sv
rtl/wii_log2.sv
rtl/wii_div.sv
rtl/well_index_isotropic.sv
verif/tb.sv
